// File: design/ald_pkg.sv
`default_nettype none
package ald_pkg;

    // event kinds carried on the input tuser
    localparam logic [1:0] CMD_RESET   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_SERVICE = 2'd2;

    // configuration register indexes
    localparam logic [7:0] REG_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_FLUSH     = 8'd1;
    localparam logic [7:0] REG_FALLBACK  = 8'd2;
    localparam logic [7:0] REG_MARGIN    = 8'd3;

    // reset values of the configuration registers
    localparam logic [7:0]  THRESHOLD_RST = 8'd10;
    localparam logic [15:0] FLUSH_RST     = 16'd500;
    localparam logic [15:0] FALLBACK_RST  = 16'd50;
    localparam logic [7:0]  MARGIN_RST    = 8'd5;

    localparam logic [7:0] RUN_MAX = 8'd255;

    typedef struct packed {
        logic [7:0]  refusal_threshold;
        logic [15:0] flush_limit_ms;
        logic [15:0] dwell_fallback_ms;
        logic [7:0]  dwell_margin_ms;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  run_count;
        logic        drop_pending;
        logic [31:0] deadline_ms;
        logic [31:0] dwell_until_ms;
        logic        dwell_valid;
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic        refresh_busy;
        logic        owner_is_link;
        logic        tx_empty;
        logic        rx_pending;
        logic [15:0] conn_interval_ms;
    } t_item;

endpackage
`default_nettype wire

// File: design/ald_cfg_regs.sv
`default_nettype none
module ald_cfg_regs
    import ald_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.refusal_threshold <= THRESHOLD_RST;
            r_cfg.flush_limit_ms    <= FLUSH_RST;
            r_cfg.dwell_fallback_ms <= FALLBACK_RST;
            r_cfg.dwell_margin_ms   <= MARGIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_cfg.refusal_threshold <= i_cfg_data[7:0];
                REG_FLUSH:     r_cfg.flush_limit_ms    <= i_cfg_data;
                REG_FALLBACK:  r_cfg.dwell_fallback_ms <= i_cfg_data;
                REG_MARGIN:    r_cfg.dwell_margin_ms   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: design/ald_step.sv
`default_nettype none
module ald_step
    import ald_pkg::*;
(
    input  wire t_cfg   i_cfg,
    input  wire t_state i_st,
    input  wire t_item  i_item,
    output t_state      o_st,
    output logic        o_drop
);

    logic [7:0]  run_inc;
    logic [16:0] dwell_len;
    logic [15:0] iv;
    logic [31:0] dwell_end;
    logic [31:0] end_minus_dl;
    logic [31:0] now_minus_dl;
    logic [31:0] now_minus_dw;
    logic        expired;
    logic        end_after_dl;
    logic        set_dwell;
    logic        dwelled;

    // saturating run count
    assign run_inc = (i_st.run_count == RUN_MAX) ? RUN_MAX : i_st.run_count + 8'd1;

    // dwell end candidate: now + interval (or fallback) + margin
    assign iv        = (i_item.conn_interval_ms != 16'd0) ? i_item.conn_interval_ms
                                                          : i_cfg.dwell_fallback_ms;
    assign dwell_len = {1'b0, iv} + {9'd0, i_cfg.dwell_margin_ms};
    assign dwell_end = i_item.now_ms + {15'd0, dwell_len};

    // wrap-safe time compares
    assign end_minus_dl = dwell_end - i_st.deadline_ms;
    assign end_after_dl = (end_minus_dl != 32'd0) && !end_minus_dl[31];
    assign now_minus_dl = i_item.now_ms - i_st.deadline_ms;
    assign expired      = !now_minus_dl[31];
    assign now_minus_dw = i_item.now_ms - i_st.dwell_until_ms;
    assign set_dwell    = i_item.tx_empty && !i_st.dwell_valid;

    // a fresh dwell end sits dwell_len ahead of now, or is clipped to the deadline
    always_comb begin
        if (set_dwell) begin
            dwelled = end_after_dl ? expired : (dwell_len == 17'd0);
        end else begin
            dwelled = i_st.dwell_valid && !now_minus_dw[31];
        end
    end

    // per-event next state
    always_comb begin
        o_st   = i_st;
        o_drop = 1'b0;
        unique case (i_item.command)
            CMD_RESET: begin
                o_st = '0;
            end
            CMD_ADVANCE: begin
                if (!i_st.drop_pending) begin
                    o_st.run_count = run_inc;
                    if (run_inc >= i_cfg.refusal_threshold) begin
                        o_st.drop_pending   = 1'b1;
                        o_st.deadline_ms    = i_item.now_ms
                                            + {16'd0, i_cfg.flush_limit_ms};
                        o_st.dwell_until_ms = 32'd0;
                        o_st.dwell_valid    = 1'b0;
                    end
                end
            end
            CMD_SERVICE: begin
                if (i_st.drop_pending && !i_item.refresh_busy) begin
                    if (!i_item.owner_is_link) begin
                        o_st = '0;
                    end else begin
                        if (set_dwell) begin
                            o_st.dwell_until_ms = end_after_dl ? i_st.deadline_ms
                                                               : dwell_end;
                            o_st.dwell_valid    = 1'b1;
                        end
                        if (expired || (dwelled && !i_item.rx_pending)) begin
                            o_st   = '0;
                            o_drop = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: design/auth_abuse_link_drop_controller.sv
`default_nettype none
// Link-drop controller for runs of authentication refusals.
// Slave stream (i_s_*): one beat per event; the kind rides on tuser
// (reset run, refusal advance, service pass), the time and link status on tdata.
// Master stream (o_m_*): one result beat per event with the drop decision,
// the armed flag and the refusal run count after that event.
// Config channel (i_cfg_*): register index and data, always ready; write
// only while no event is in flight.
// An accepted event is held in the input register, then takes one pass of
// next-state logic into the result register, where its result is offered.
// Throughput: one event per cycle while the receiver takes results, set by the
// state update loop through the run count, drop and dwell registers.
// Reset (synchronous, active low) clears the run state, empties both
// registers and restores the configuration defaults.
// A stalled receiver holds the result beat; one more event waits in the input
// register and then the slave tready drops until the result is taken.
module auth_abuse_link_drop_controller
    import ald_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [31:0] now_ms, [32] refresh_busy, [33] owner_is_link, [34] tx_empty,
    // [35] rx_pending, [51:36] conn_interval_ms, [55:52] zero
    input  wire logic [55:0] i_s_tdata,
    // [1:0] command
    input  wire logic [1:0]  i_s_tuser,
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] drop_link, [1] drop_armed, [9:2] refusal_run, [15:10] zero
    output logic [15:0]      o_m_tdata,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg   cfg;
    t_item  r_in;
    logic   r_in_valid;
    t_state r_st;
    t_state n_st;
    logic   n_drop;
    logic   r_out_valid;
    logic [15:0] r_out;
    logic   out_free;
    logic   step_fire;

    assign o_cfg_ready = 1'b1;

    ald_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // handshake: result register frees when empty or being taken
    assign out_free   = !r_out_valid || i_m_tready;
    assign step_fire  = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.command          <= i_s_tuser;
            r_in.now_ms           <= i_s_tdata[31:0];
            r_in.refresh_busy     <= i_s_tdata[32];
            r_in.owner_is_link    <= i_s_tdata[33];
            r_in.tx_empty         <= i_s_tdata[34];
            r_in.rx_pending       <= i_s_tdata[35];
            r_in.conn_interval_ms <= i_s_tdata[51:36];
        end
    end

    ald_step u_step (
        .i_cfg  (cfg),
        .i_st   (r_st),
        .i_item (r_in),
        .o_st   (n_st),
        .o_drop (n_drop)
    );

    // run state moves with each event leaving the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (step_fire) begin
            r_st <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= {6'd0, n_st.run_count, n_st.drop_pending, n_drop};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // a drop beat always reports cleared state
    a_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[9:1] == 9'd0))
        else $error("drop result with state left over");

    // a dwell is only ever set while a drop is armed
    a_dwell_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.drop_pending |-> !r_st.dwell_valid)
        else $error("dwell set without a pending drop");

    // run state only changes when an event steps through
    a_state_hold: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && !$past(step_fire)) |-> $stable(r_st))
        else $error("run state changed without an event");

    // the result of an event that left armed state reports that state
    a_armed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire |=> (o_m_tdata[1] == r_st.drop_pending
                       && o_m_tdata[9:2] == r_st.run_count))
        else $error("result beat disagrees with run state");

endmodule
`default_nettype wire

// File: tb/sv/auth_abuse_link_drop_controller_test.sv
`default_nettype none
module auth_abuse_link_drop_controller_test;
    import ald_pkg::*;

    // the one event code the package leaves undefined
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;

    // result beat, lowest bit first: drop_link, drop_armed, refusal_run
    typedef struct packed {
        logic [7:0] refusal_run;
        logic       drop_armed;
        logic       drop_link;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [55:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [15:0] o_m_tdata;
    wire         o_cfg_ready;

    auth_abuse_link_drop_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the link state and settings
    t_state      link_st;
    t_cfg        link_cfg;
    t_verdict    awaited_verdicts[$];
    logic [31:0] clock_ms = '0;

    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 51;
    int unsigned hold_left = 0;
    int unsigned events_sent = 0;
    int unsigned results_seen = 0;
    int unsigned drops_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit hit, %0d results still awaited", $time,
                     awaited_verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // wrap-safe time compares on the signed 32-bit difference
    function automatic logic ms_not_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

    function automatic logic ms_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    // next drop decision for one event, updating the shadow state
    function automatic t_verdict decide_drop(input t_item ev);
        t_verdict    v;
        logic        expired;
        logic        dwelled;
        logic [31:0] iv;
        logic [31:0] dwell_end;
        v = '0;
        case (ev.command)
            CMD_RESET: begin
                link_st = '0;
            end
            CMD_ADVANCE: begin
                if (!link_st.drop_pending) begin
                    if (link_st.run_count != RUN_MAX)
                        link_st.run_count = link_st.run_count + 8'd1;
                    if (link_st.run_count >= link_cfg.refusal_threshold) begin
                        link_st.drop_pending   = 1'b1;
                        link_st.deadline_ms    = ev.now_ms + {16'd0, link_cfg.flush_limit_ms};
                        link_st.dwell_until_ms = '0;
                        link_st.dwell_valid    = 1'b0;
                    end
                end
            end
            CMD_SERVICE: begin
                if (link_st.drop_pending && !ev.refresh_busy) begin
                    if (!ev.owner_is_link) begin
                        link_st = '0;
                    end else begin
                        expired = ms_not_before(ev.now_ms, link_st.deadline_ms);
                        // dwell is set once, on the first pass with the queue drained
                        if (ev.tx_empty && !link_st.dwell_valid) begin
                            iv = (ev.conn_interval_ms != 16'd0) ? {16'd0, ev.conn_interval_ms}
                                                                : {16'd0, link_cfg.dwell_fallback_ms};
                            dwell_end = ev.now_ms + iv + {24'd0, link_cfg.dwell_margin_ms};
                            link_st.dwell_until_ms = ms_after(dwell_end, link_st.deadline_ms)
                                                   ? link_st.deadline_ms : dwell_end;
                            link_st.dwell_valid = 1'b1;
                        end
                        dwelled = link_st.dwell_valid
                                && ms_not_before(ev.now_ms, link_st.dwell_until_ms);
                        if (expired || (dwelled && !ev.rx_pending)) begin
                            link_st = '0;
                            v.drop_link = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        v.drop_armed  = link_st.drop_pending;
        v.refusal_run = link_st.run_count;
        return v;
    endfunction

    function automatic t_item make_event(input logic [1:0] cmd, input logic [31:0] now,
                                         input logic busy, input logic owner,
                                         input logic txe, input logic rxp,
                                         input logic [15:0] interval);
        t_item ev;
        ev.command          = cmd;
        ev.now_ms           = now;
        ev.refresh_busy     = busy;
        ev.owner_is_link    = owner;
        ev.tx_empty         = txe;
        ev.rx_pending       = rxp;
        ev.conn_interval_ms = interval;
        return ev;
    endfunction

    // offer one event beat and log its expected verdict on acceptance
    task automatic send_event(input t_item ev);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= ev.command;
        i_s_tdata  <= {4'd0, ev.conn_interval_ms, ev.rx_pending, ev.tx_empty,
                       ev.owner_is_link, ev.refresh_busy, ev.now_ms};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        awaited_verdicts.push_back(decide_drop(ev));
        events_sent++;
    endtask

    // register write, only once the block has gone quiet
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        i_s_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_THRESHOLD: link_cfg.refusal_threshold = val[7:0];
            REG_FLUSH:     link_cfg.flush_limit_ms    = val;
            REG_FALLBACK:  link_cfg.dwell_fallback_ms = val;
            REG_MARGIN:    link_cfg.dwell_margin_ms   = val[7:0];
            default: ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // result checker and receiver ready
    always @(posedge i_clk) begin : result_check
        t_verdict got;
        t_verdict want;
        if (o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[9:0];
            results_seen++;
            if (awaited_verdicts.size() == 0) begin
                $display("%0t: result beat %h with nothing expected", $time, o_m_tdata);
                errors++;
            end else begin
                want = awaited_verdicts.pop_front();
                if (want.drop_link) drops_seen++;
                compare_field("drop_link", {7'd0, want.drop_link}, {7'd0, got.drop_link});
                compare_field("drop_armed", {7'd0, want.drop_armed}, {7'd0, got.drop_armed});
                compare_field("refusal_run", want.refusal_run, got.refusal_run);
            end
        end
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // time moves in small steps, now and then a far jump
    function automatic logic [31:0] next_now();
        if ($urandom_range(49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 30);
        return clock_ms;
    endfunction

    function automatic logic [15:0] rand_interval();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 5)
            return 16'd0;
        else if (r < 17)
            return 16'($urandom_range(1, 200));
        else
            return 16'($urandom);
    endfunction

    function automatic t_item rand_service();
        return make_event(CMD_SERVICE, next_now(), $urandom_range(99) < 15,
                          $urandom_range(99) >= 4, 1'($urandom_range(1)),
                          $urandom_range(99) < 40, rand_interval());
    endfunction

    function automatic t_item rand_advance();
        return make_event(CMD_ADVANCE, next_now(), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), rand_interval());
    endfunction

    // new settings, extremes included
    task automatic pick_config();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(19))
            0:       v[7:0] = 8'd255;
            1:       v[7:0] = 8'd1;
            2:       v[7:0] = 8'd0;
            default: v[7:0] = 8'($urandom_range(2, 8));
        endcase
        write_reg(REG_THRESHOLD, v);
        case ($urandom_range(9))
            0:       v = 16'hFFFF;
            1:       v = 16'd0;
            default: v = 16'($urandom_range(1, 300));
        endcase
        write_reg(REG_FLUSH, v);
        case ($urandom_range(9))
            0:       v = 16'hFFFF;
            1:       v = 16'd1;
            2:       v = 16'd0;
            default: v = 16'($urandom_range(1, 120));
        endcase
        write_reg(REG_FALLBACK, v);
        v = 16'($urandom);
        case ($urandom_range(9))
            0:       v[7:0] = 8'd255;
            1:       v[7:0] = 8'd0;
            default: v[7:0] = 8'($urandom_range(0, 40));
        endcase
        write_reg(REG_MARGIN, v);
        if ($urandom_range(3) == 0)
            write_reg(8'($urandom_range(4, 255)), 16'($urandom));
    endtask

    // one refusal run up to arming, then service passes until it resolves or 60 passes are spent
    task automatic run_episode();
        int unsigned passes;
        int unsigned r;
        if ($urandom_range(9) == 0)
            send_event(make_event(CMD_RESET, next_now(), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), rand_interval()));
        while (!link_st.drop_pending) begin
            r = $urandom_range(19);
            if (r == 0)
                send_event(make_event(CMD_UNUSED, next_now(), 1'($urandom_range(1)),
                                      1'($urandom_range(1)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)), rand_interval()));
            else if (r == 1)
                send_event(rand_service());
            else
                send_event(rand_advance());
        end
        passes = 0;
        while (link_st.drop_pending && passes < 60) begin
            if ($urandom_range(9) == 0)
                send_event(rand_advance());
            else
                send_event(rand_service());
            passes++;
        end
    endtask

    // every event kind on a short drop cycle
    task automatic test_event_kinds();
        write_reg(REG_THRESHOLD, 16'd2);
        send_event(make_event(CMD_RESET, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF));
        send_event(make_event(CMD_SERVICE, 32'd5, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0));
        send_event(make_event(CMD_ADVANCE, 32'd100, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_ADVANCE, 32'd101, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        // armed: further refusals are ignored, busy passes skipped
        send_event(make_event(CMD_ADVANCE, 32'd102, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd103, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd104, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd110, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd170, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd171, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        // owner gone clears without a drop
        send_event(make_event(CMD_ADVANCE, 32'd200, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_ADVANCE, 32'd201, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd202, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0));
    endtask

    // deadline across the wrap and a dwell that ends at zero
    task automatic test_time_wrap();
        send_event(make_event(CMD_ADVANCE, 32'hFFFF_FF00, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_ADVANCE, 32'hFFFF_FF01, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'h0000_01F5, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0));
        send_event(make_event(CMD_ADVANCE, 32'hFFFF_FFDF, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_ADVANCE, 32'hFFFF_FFE0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd11));
        send_event(make_event(CMD_SERVICE, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
    endtask

    // zero threshold, zero fallback, dwell clipped to the deadline
    task automatic test_zero_settings();
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_FALLBACK, 16'd0);
        write_reg(8'hFF, 16'hFFFF);
        send_event(make_event(CMD_ADVANCE, 32'd1000, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd1000, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd1005, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_ADVANCE, 32'd2000, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
        send_event(make_event(CMD_SERVICE, 32'd2001, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF));
        send_event(make_event(CMD_SERVICE, 32'd2500, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0));
    endtask

    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input int unsigned n);
        int unsigned start;
        int unsigned cfg_start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = events_sent;
        while (events_sent - start < n) begin
            pick_config();
            cfg_start = events_sent;
            while (events_sent - cfg_start < 150 && events_sent - start < n)
                run_episode();
        end
    endtask

    // receiver stalls for a long stretch while events keep coming
    task automatic test_backpressure();
        int unsigned start;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        @(posedge i_clk);
        start = events_sent;
        while (events_sent - start < 40)
            run_episode();
    endtask

    initial begin
        link_cfg = {THRESHOLD_RST, FLUSH_RST, FALLBACK_RST, MARGIN_RST};
        link_st  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_event_kinds();
        test_time_wrap();
        test_zero_settings();
        test_random_traffic(14, 51, 600);
        test_random_traffic(51, 14, 600);
        test_backpressure();
        test_random_traffic(0, 0, 600);

        // drain
        i_s_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d events over %0d register writes, checked %0d results",
                 events_sent, cfg_writes, results_seen);
        $display("%0d link drops seen, %0d mismatches", drops_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
